// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL, clocked on clk and muted in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a |-> b on the same edge
`define ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// a |=> b on the next edge
`define ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/irdq_pkg.sv -----
package irdq_pkg;

	// microseconds to nanoseconds
	localparam logic [9:0] US_TO_NS = 10'd1000;

	// register reset values
	localparam logic [15:0] QUANTUM_RESET = 16'd17067;
	localparam logic [15:0] LIMIT_RESET   = 16'd4608;

	// quotient bits produced by the serial divider
	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	// configuration register index
	localparam int CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_QUANTUM_NS  = 1'b0,
		CFG_FRAME_LIMIT = 1'b1
	} irdq_cfg_idx_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_ROUND,
		S_DIV,
		S_CLAMP,
		S_MUL,
		S_RESID
	} irdq_state_t;

	// divider request and response
	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [15:0] divisor;
	} irdq_div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} irdq_div_rsp_t;

endpackage

// ----- hdl/irdq_div.sv -----
`include "assert_macros.svh"

// Restoring divider, one quotient bit per cycle
module irdq_div import irdq_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  irdq_div_req_t req,
	output irdq_div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [15:0]          rem_q;
	logic [31:0]          quo_q;
	logic [15:0]          div_q;

	logic [16:0] trial;
	logic        ge;
	logic [16:0] diff;

	// one shift-subtract step
	always_comb begin
		trial = {rem_q, quo_q[31]};
		ge    = trial >= {1'b0, div_q};
		diff  = trial - {1'b0, div_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: quotient bits shift in where dividend bits shift out
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[15:0] : trial[15:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	`ASSERT_IMPL(a_no_restart, req.start, !busy_q, "divider started while busy")
	`ASSERT_NEXT(a_done_pulse, done_q, !done_q && !busy_q, "divider done not a single pulse")

endmodule

// ----- hdl/ir_duration_quantizer_core.sv -----
// Sequence: check, round, 32 divider steps, done, clamp, multiply and residual
//   update lie between request accept and result valid; the residual update
//   waits while the output stalls. A new request is taken only in idle; a request
//   into a full frame goes back to idle from check with no result. The output
//   register lets the next request enter while a result waits.
// Reset: clears frame state and output valid, loads register defaults.
`include "assert_macros.svh"

module ir_duration_quantizer_core import irdq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_wdata,
	// input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [15:0]          duration_us,
	input  logic                 first_of_frame,
	input  logic                 last_of_frame,
	// output channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 level,
	output logic [15:0]          quanta_count,
	output logic [15:0]          start_offset,
	output logic                 truncated,
	output logic                 frame_end
);

	irdq_state_t state_q, next_state;

	logic [15:0] quantum_q, limit_q;

	// frame state
	logic [31:0] residual_q;
	logic        space_q;
	logic [15:0] used_q;
	logic        full_q;

	// request and work registers
	logic [15:0] dur_q;
	logic        last_q;
	logic [32:0] want_q;
	logic [15:0] cnt_q;
	logic        clamp_q;
	logic [31:0] prod_q;

	logic        out_valid_q;

	irdq_div_req_t div_req;
	irdq_div_rsp_t div_rsp;

	logic        in_acc;
	logic        out_free;
	logic        skip;
	logic        commit;
	logic [15:0] q_eff;
	logic [25:0] dur_ns;
	logic [32:0] want_d;
	logic [32:0] num_d;
	logic        num_pos;
	logic [15:0] room;
	logic [31:0] cnt_min;
	logic        clamp_d;
	logic [15:0] cnt_d;
	logic [31:0] prod_d;
	logic [33:0] res_diff;
	logic [31:0] res_sat;
	logic [16:0] used_sum;

	irdq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// arithmetic
	always_comb begin
		q_eff    = (quantum_q == '0) ? 16'd1 : quantum_q;
		dur_ns   = 26'(dur_q) * 26'(US_TO_NS);
		want_d   = {residual_q[31], residual_q} + {7'b0, dur_ns};
		num_d    = want_q + {18'b0, q_eff[15:1]};
		num_pos  = !num_d[32] && (num_d != '0);
		room     = limit_q - used_q;
		cnt_min  = (div_rsp.quotient == '0) ? 32'd1 : div_rsp.quotient;
		clamp_d  = cnt_min > {16'b0, room};
		cnt_d    = clamp_d ? room : cnt_min[15:0];
		prod_d   = {16'b0, cnt_q} * {16'b0, q_eff};
		res_diff = {want_q[32], want_q} - {2'b0, prod_q};
		if (res_diff[33:31] == 3'b000 || res_diff[33:31] == 3'b111) begin
			res_sat = res_diff[31:0];
		end else if (res_diff[33]) begin
			res_sat = 32'h8000_0000;
		end else begin
			res_sat = 32'h7FFF_FFFF;
		end
		used_sum = {1'b0, used_q} + {1'b0, cnt_q};
	end

	// next state
	always_comb begin
		next_state = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) next_state = S_CHECK;
			end
			S_CHECK: begin
				next_state = (full_q || used_q >= limit_q) ? S_IDLE : S_ROUND;
			end
			S_ROUND: next_state = S_DIV;
			S_DIV: begin
				if (div_rsp.done) next_state = S_CLAMP;
			end
			S_CLAMP: next_state = S_MUL;
			S_MUL:   next_state = S_RESID;
			S_RESID: begin
				if (out_free) next_state = S_IDLE;
			end
			default: next_state = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall         = (state_q != S_IDLE);
		in_acc           = in_valid && !in_stall;
		out_free         = !out_valid_q || !out_stall;
		skip             = (state_q == S_CHECK) && (full_q || used_q >= limit_q);
		commit           = (state_q == S_RESID) && out_free;
		div_req.start    = (state_q == S_ROUND);
		div_req.dividend = num_pos ? num_d[31:0] : '0;
		div_req.divisor  = q_eff;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= next_state;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QUANTUM_RESET;
			limit_q   <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (irdq_cfg_idx_t'(cfg_index))
				CFG_QUANTUM_NS:  quantum_q <= cfg_wdata;
				CFG_FRAME_LIMIT: limit_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// frame state: cleared on frame start, marked full on a skipped request, updated when a run commits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			residual_q <= '0;
			space_q    <= 1'b0;
			used_q     <= '0;
			full_q     <= 1'b0;
		end else if (in_acc && first_of_frame) begin
			residual_q <= '0;
			space_q    <= 1'b0;
			used_q     <= '0;
			full_q     <= 1'b0;
		end else if (skip) begin
			full_q <= 1'b1;
		end else if (commit) begin
			residual_q <= res_sat;
			space_q    <= !space_q;
			used_q     <= used_sum[15:0];
			full_q     <= (used_sum[15:0] >= limit_q);
		end
	end

	// work registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			dur_q  <= duration_us;
			last_q <= last_of_frame;
		end
		if (state_q == S_CHECK) want_q <= want_d;
		if (state_q == S_CLAMP) begin
			cnt_q   <= cnt_d;
			clamp_q <= clamp_d;
		end
		if (state_q == S_MUL) prod_q <= prod_d;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (commit) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			level        <= !space_q;
			quanta_count <= cnt_q;
			start_offset <= used_q;
			truncated    <= clamp_q;
			frame_end    <= last_q;
		end
	end

	assign out_valid = out_valid_q;

	`ASSERT_NEXT(a_accept_check, in_acc, state_q == S_CHECK, "accepted request did not reach check")
	`ASSERT_IMPL(a_done_in_div, div_rsp.done, state_q == S_DIV, "divider done outside divide state")
	`ASSERT_NEXT(a_result_nonzero, commit, out_valid_q && quanta_count != '0, "result lost or empty")

endmodule
